### hw/rtl/lbb_pkg.sv
// Shared types and constants for the LRU byte-budget cache directory.
// No dependencies; imported by every module of the block.
package lbb_pkg;

   localparam int ENTRIES  = 16;
   localparam int KEY_BITS = 32;
   localparam int SIZE_W   = 21;
   localparam int TOTAL_W  = 22;
   localparam int CSR_AW   = 3;

   localparam logic [SIZE_W-1:0] CAPACITY_RESET = SIZE_W'(1048576);
   localparam logic [SIZE_W-1:0] MAX_OBJ_RESET  = SIZE_W'(102400);

   localparam logic ACTION_LOOKUP = 1'b0;
   localparam logic ACTION_INSERT = 1'b1;

   // register select is address bit 2
   localparam logic REG_CAPACITY = 1'b0;
   localparam logic REG_MAX_OBJ  = 1'b1;

   typedef enum logic [2:0] {
      KIND_HIT      = 3'd0,
      KIND_MISS     = 3'd1,
      KIND_EVICTED  = 3'd2,
      KIND_INSERTED = 3'd3,
      KIND_REJECTED = 3'd4
   } kind_type;

   typedef struct packed {
      logic                action;
      logic [KEY_BITS-1:0] key_tag;
      logic [SIZE_W-1:0]   object_size;
   } req_type;

   typedef struct packed {
      kind_type            kind;
      logic [KEY_BITS-1:0] result_key;
      logic [SIZE_W-1:0]   result_size;
      logic [TOTAL_W-1:0]  total_bytes;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic                valid;
      logic [KEY_BITS-1:0] key;
      logic [SIZE_W-1:0]   size;
   } entry_type;

   typedef struct packed {
      logic shift_dn;   // take left neighbor (toward most recent)
      logic shift_up;   // take right neighbor (toward least recent)
      logic clear;
   } cell_cmd_type;

endpackage

### hw/rtl/lbb_cell.sv
// One directory slot; its position in the row is its recency rank.
// Depends on lbb_pkg.
module lbb_cell import lbb_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cell_cmd_type        cmd,
   input  entry_type           left_entry,
   input  entry_type           right_entry,
   input  logic [KEY_BITS-1:0] probe_key,
   output entry_type           entry,
   output logic                match
);

   logic                valid_ff, valid_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [SIZE_W-1:0]   size_ff, size_in;

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      size_in  = size_ff;
      if (cmd.clear) begin
         valid_in = 1'b0;
      end else if (cmd.shift_dn) begin
         valid_in = left_entry.valid;
         key_in   = left_entry.key;
         size_in  = left_entry.size;
      end else if (cmd.shift_up) begin
         valid_in = right_entry.valid;
         key_in   = right_entry.key;
         size_in  = right_entry.size;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      key_ff  <= key_in;
      size_ff <= size_in;
   end

   assign entry = '{valid: valid_ff, key: key_ff, size: size_ff};
   assign match = valid_ff && (key_ff == probe_key);

endmodule

### hw/rtl/lbb_ctrl.sv
// Sequencer: decodes an item, steers the cell row, tracks the byte total
// and drives the result register. Depends on lbb_pkg.
module lbb_ctrl import lbb_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_type             req_payload,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_type             rsp_payload,
   input  logic [SIZE_W-1:0]   capacity,
   input  logic [SIZE_W-1:0]   max_obj,
   input  entry_type           ents [ENTRIES],
   input  logic [ENTRIES-1:0]  match,
   output cell_cmd_type        cmds [ENTRIES],
   output entry_type           load_entry,
   output logic [KEY_BITS-1:0] probe_key
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_LOOK  = 3'b010,
      ST_EVICT = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   req_type            item_ff, item_in;
   logic [TOTAL_W-1:0] stored_ff, stored_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [ENTRIES-1:0]  le_mask, ge_mask, victim;
   logic [KEY_BITS-1:0] hit_key, vic_key;
   logic [SIZE_W-1:0]   hit_size, vic_size;
   logic                hit_any, out_free, fits, acc;
   logic [TOTAL_W:0]    need;

   always_comb begin
      hit_key  = '0;
      hit_size = '0;
      vic_key  = '0;
      vic_size = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         victim[i] = ents[i].valid && ((i == ENTRIES-1) || !ents[(i+1) % ENTRIES].valid);
         if (match[i]) begin
            hit_key  = hit_key | ents[i].key;
            hit_size = hit_size | ents[i].size;
         end
         if (victim[i]) begin
            vic_key  = vic_key | ents[i].key;
            vic_size = vic_size | ents[i].size;
         end
      end
      acc = 1'b0;
      for (int i = ENTRIES-1; i >= 0; i--) begin
         acc = acc | match[i];
         le_mask[i] = acc;
      end
      acc = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
         acc = acc | match[i];
         ge_mask[i] = acc;
      end
   end

   assign hit_any  = |match;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign need     = {1'b0, stored_ff} + (TOTAL_W+1)'(item_ff.object_size);
   assign fits     = need <= (TOTAL_W+1)'(capacity);
   assign probe_key = item_ff.key_tag;

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      stored_in    = stored_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      load_entry   = '{valid: 1'b1, key: item_ff.key_tag, size: item_ff.object_size};
      for (int i = 0; i < ENTRIES; i++) begin
         cmds[i] = '0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in  = req_payload;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (item_ff.action == ACTION_LOOKUP) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
                  if (hit_any && hit_size <= max_obj) begin
                     load_entry = '{valid: 1'b1, key: hit_key, size: hit_size};
                     for (int i = 0; i < ENTRIES; i++) begin
                        cmds[i].shift_dn = le_mask[i];
                     end
                     rsp_in = '{kind: KIND_HIT, result_key: hit_key,
                                result_size: hit_size, total_bytes: stored_ff, last: 1'b1};
                  end else begin
                     rsp_in = '{kind: KIND_MISS, result_key: item_ff.key_tag,
                                result_size: '0, total_bytes: stored_ff, last: 1'b1};
                  end
               end
            end else if (item_ff.object_size > max_obj) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
                  rsp_in = '{kind: KIND_REJECTED, result_key: item_ff.key_tag,
                             result_size: item_ff.object_size, total_bytes: stored_ff,
                             last: 1'b1};
               end
            end else begin
               // same tag already stored: drop it silently, close the gap
               if (hit_any) begin
                  for (int i = 0; i < ENTRIES; i++) begin
                     cmds[i].shift_up = ge_mask[i];
                  end
                  stored_in = stored_ff - TOTAL_W'(hit_size);
               end
               state_in = ST_EVICT;
            end
         end
         ST_EVICT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (!ents[0].valid || (fits && !ents[ENTRIES-1].valid)) begin
                  for (int i = 0; i < ENTRIES; i++) begin
                     cmds[i].shift_dn = 1'b1;
                  end
                  stored_in = stored_ff + TOTAL_W'(item_ff.object_size);
                  rsp_in = '{kind: KIND_INSERTED, result_key: item_ff.key_tag,
                             result_size: item_ff.object_size,
                             total_bytes: stored_ff + TOTAL_W'(item_ff.object_size),
                             last: 1'b1};
                  state_in = ST_IDLE;
               end else begin
                  for (int i = 0; i < ENTRIES; i++) begin
                     cmds[i].clear = victim[i];
                  end
                  stored_in = stored_ff - TOTAL_W'(vic_size);
                  rsp_in = '{kind: KIND_EVICTED, result_key: vic_key, result_size: vic_size,
                             total_bytes: stored_ff - TOTAL_W'(vic_size), last: 1'b0};
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         stored_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stored_ff    <= stored_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### hw/rtl/lru_byte_budget_cache_policy.sv
// LRU directory with byte budget: row of recency-ordered cells plus sequencer.
// Lookup and reject: the item is registered, then decided in the look state, which registers the result.
// Insert: look state, then the evict state registers one evicted result per eviction, then the inserted result;
// a result register held by rsp_stall holds the sequencer. A new item is taken only back in idle.
// Synchronous reset empties the directory, zeroes the byte total and restores
// capacity 1048576 and object limit 102400. Depends on lbb_pkg, lbb_cell, lbb_ctrl.
module lru_byte_budget_cache_policy import lbb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_payload,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   logic [SIZE_W-1:0]   capacity_ff, capacity_in, max_obj_ff, max_obj_in;
   entry_type           ents [ENTRIES];
   logic [ENTRIES-1:0]  match;
   cell_cmd_type        cmds [ENTRIES];
   entry_type           load_entry;
   logic [KEY_BITS-1:0] probe_key;
   logic                csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      capacity_in = capacity_ff;
      max_obj_in  = max_obj_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_CAPACITY: capacity_in = csr_pwdata[SIZE_W-1:0];
            REG_MAX_OBJ:  max_obj_in  = csr_pwdata[SIZE_W-1:0];
            default: ;
         endcase
      end
      unique case (csr_paddr[2])
         REG_CAPACITY: csr_prdata = 32'(capacity_ff);
         REG_MAX_OBJ:  csr_prdata = 32'(max_obj_ff);
         default:      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
         max_obj_ff  <= MAX_OBJ_RESET;
      end else begin
         capacity_ff <= capacity_in;
         max_obj_ff  <= max_obj_in;
      end
   end

   lbb_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .capacity    (capacity_ff),
      .max_obj     (max_obj_ff),
      .ents        (ents),
      .match       (match),
      .cmds        (cmds),
      .load_entry  (load_entry),
      .probe_key   (probe_key)
   );

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      entry_type left_e, right_e;
      if (i == 0) begin : g_first
         assign left_e = load_entry;
      end else begin : g_mid_l
         assign left_e = ents[i-1];
      end
      if (i == ENTRIES-1) begin : g_last
         assign right_e = '0;
      end else begin : g_mid_r
         assign right_e = ents[i+1];
      end
      lbb_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmds[i]),
         .left_entry  (left_e),
         .right_entry (right_e),
         .probe_key   (probe_key),
         .entry       (ents[i]),
         .match       (match[i])
      );
   end

endmodule
